>>> design/huffman_code_bit_packer_unit_macros.svh
// Assertion macros for the Huffman code bit packer checker.
// Needs clk and rst_n in the scope of each use.
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_MACROS_SVH

// antecedent holds -> consequent holds on the next edge
`define HCBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbp: next-cycle property failed");

// antecedent holds -> signal unchanged on the next edge
`define HCBP_ASSERT_HOLD(lbl, ante, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> $stable(sig)) \
        else $error("hcbp: held value changed");

`endif

>>> design/hcbp_pkg.sv
// Shared constants, op codes and control structs of the Huffman code bit packer.
// No dependencies.
`default_nettype none

package hcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 16;

    localparam int SYM_W     = 8;
    localparam int CODE_W    = 16;
    localparam int LEN_W     = 5;
    localparam int BYTE_W    = 8;
    localparam int SYM_IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int EFF_MAX   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic load_we;
        logic rd_en;
        logic commit_enc;
        logic commit_flush;
    } hcbp_cmd_t;

    typedef struct packed {
        logic out_empty;
    } hcbp_sts_t;

endpackage

`default_nettype wire

>>> design/huffman_code_bit_packer_unit.sv
// Top level of the Huffman code bit packer: controller plus datapath.
// Depends on hcbp_pkg, hcbp_ctrl, hcbp_datapath.
//
// Input channel (in_valid/in_stall) carries op, symbol, code_value, code_length.
// A load word writes one table entry in the cycle it is taken; the next word
// may follow straight away. An encode word reads the table on acceptance and
// merges the code into the bit accumulator from the ENC state; a flush goes
// to the FLUSH state, and in_stall is high while either state is held.
// The merge waits while either output slot still holds a byte, so a
// receiver that stalls holds off the next encode or flush and all words behind it.
// Output channel (out_valid/out_stall) carries out_byte and last; first byte
// of an encode or flush appears the cycle after its merge, a second byte of
// the same encode follows from a holding slot as soon as the first is taken.
// An encode gives 0 to 2 bytes, a flush exactly one; last marks the final one.
// Reset empties the accumulator and output slots; the code table is not
// cleared and an entry must be loaded before it is encoded.
`default_nettype none

module huffman_code_bit_packer_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    op,
    input  wire logic [hcbp_pkg::SYM_W-1:0]    symbol,
    input  wire logic [hcbp_pkg::CODE_W-1:0]   code_value,
    input  wire logic [hcbp_pkg::LEN_W-1:0]    code_length,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
    output logic                               last
);
    import hcbp_pkg::*;

    hcbp_cmd_t cmd;
    hcbp_sts_t sts;

    hcbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd)
    );

    hcbp_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .symbol      (symbol),
        .code_value  (code_value),
        .code_length (code_length),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .last        (last)
    );

endmodule

`default_nettype wire

>>> design/hcbp_ctrl.sv
// Controller FSM: accepts words, sequences table lookup and commit.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        op,
    input  wire hcbp_pkg::hcbp_sts_t sts,
    output hcbp_pkg::hcbp_cmd_t    cmd
);
    import hcbp_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ENC   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next       = state_reg;
        cmd.load_we      = 1'b0;
        cmd.rd_en        = 1'b0;
        cmd.commit_enc   = 1'b0;
        cmd.commit_flush = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_LOAD:   cmd.load_we = 1'b1;
                        OP_ENCODE:
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = ST_ENC;
                        end
                        OP_FLUSH:  state_next = ST_FLUSH;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ENC:
            begin
                // wait until both output slots are free
                if (sts.out_empty)
                begin
                    cmd.commit_enc = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_empty)
                begin
                    cmd.commit_flush = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> design/hcbp_datapath.sv
// Datapath: code table memory, bit accumulator, merge logic, two-slot output buffer.
// Depends on hcbp_pkg.
`default_nettype none

module hcbp_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hcbp_pkg::hcbp_cmd_t           cmd,
    output hcbp_pkg::hcbp_sts_t                sts,
    input  wire logic [hcbp_pkg::SYM_W-1:0]    symbol,
    input  wire logic [hcbp_pkg::CODE_W-1:0]   code_value,
    input  wire logic [hcbp_pkg::LEN_W-1:0]    code_length,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
    output logic                               last
);
    import hcbp_pkg::*;

    localparam int ENT_W = LEN_W + CODE_W;
    localparam int MRG_W = 24;

    logic [ENT_W-1:0]     table_mem [SYMBOL_COUNT];
    logic [ENT_W-1:0]     rd_data_reg;
    logic                 sym_ok_reg;

    logic [SYM_IDX_W-1:0] idx;
    logic                 sym_ok;
    logic [LEN_W-1:0]     ld_len;
    logic [CODE_W:0]      ld_mask;
    logic [CODE_W-1:0]    ld_code;

    logic [BYTE_W-1:0]    acc_reg;
    logic [BYTE_W-1:0]    acc_next;
    logic [2:0]           cnt_reg;
    logic [2:0]           cnt_next;

    logic [LEN_W-1:0]     enc_len;
    logic [CODE_W-1:0]    enc_code;
    logic [LEN_W-1:0]     total;
    logic [MRG_W-1:0]     merged;
    logic [MRG_W-1:0]     aligned;
    logic [BYTE_W:0]      res_mask;
    logic [1:0]           n_bytes;
    logic [2:0]           fl_shift;
    logic [BYTE_W-1:0]    fl_byte;

    logic                 o_valid_reg;
    logic [BYTE_W-1:0]    o_byte_reg;
    logic                 o_last_reg;
    logic                 h_valid_reg;
    logic [BYTE_W-1:0]    h_byte_reg;

    assign idx    = symbol[SYM_IDX_W-1:0];
    assign sym_ok = (int'(symbol) < SYMBOL_COUNT);

    // load: saturate length, clear bits above it
    assign ld_len  = (code_length > LEN_W'(EFF_MAX)) ? LEN_W'(EFF_MAX) : code_length;
    assign ld_mask = ((CODE_W+1)'(1) << ld_len) - (CODE_W+1)'(1);
    assign ld_code = code_value & ld_mask[CODE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && sym_ok)
            table_mem[idx] <= {ld_len, ld_code};
        if (cmd.rd_en)
        begin
            rd_data_reg <= table_mem[idx];
            sym_ok_reg  <= sym_ok;
        end
    end

    // pending bits followed by the code, then left-aligned in 24 bits
    assign enc_len  = sym_ok_reg ? rd_data_reg[ENT_W-1:CODE_W] : '0;
    assign enc_code = sym_ok_reg ? rd_data_reg[CODE_W-1:0] : '0;
    assign total    = {2'b00, cnt_reg} + enc_len;
    assign merged   = ({{(MRG_W-BYTE_W){1'b0}}, acc_reg} << enc_len)
                    | {{(MRG_W-CODE_W){1'b0}}, enc_code};
    assign aligned  = merged << (LEN_W'(MRG_W) - total);
    assign n_bytes  = total[4:3];
    assign res_mask = ((BYTE_W+1)'(1) << total[2:0]) - (BYTE_W+1)'(1);

    assign fl_shift = 3'(4'd8 - {1'b0, cnt_reg});
    assign fl_byte  = (cnt_reg == 3'd0) ? '0 : (acc_reg << fl_shift);

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (cmd.commit_enc)
        begin
            acc_next = merged[BYTE_W-1:0] & res_mask[BYTE_W-1:0];
            cnt_next = total[2:0];
        end
        else if (cmd.commit_flush)
        begin
            acc_next = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    // output slot plus a holding slot for the second byte of an encode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit_flush)
                o_valid_reg <= 1'b1;
            else if (cmd.commit_enc)
            begin
                o_valid_reg <= (n_bytes != 2'd0);
                h_valid_reg <= (n_bytes == 2'd2);
            end
            else if (o_valid_reg && !out_stall)
            begin
                o_valid_reg <= h_valid_reg;
                h_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_flush)
        begin
            o_byte_reg <= fl_byte;
            o_last_reg <= 1'b1;
        end
        else if (cmd.commit_enc)
        begin
            o_byte_reg <= aligned[MRG_W-1 -: BYTE_W];
            o_last_reg <= (n_bytes == 2'd1);
            h_byte_reg <= aligned[MRG_W-BYTE_W-1 -: BYTE_W];
        end
        else if (o_valid_reg && !out_stall && h_valid_reg)
        begin
            o_byte_reg <= h_byte_reg;
            o_last_reg <= 1'b1;
        end
    end

    assign sts.out_empty = !o_valid_reg && !h_valid_reg;
    assign out_valid     = o_valid_reg;
    assign out_byte      = o_byte_reg;
    assign last          = o_last_reg;

endmodule

`default_nettype wire

>>> design/hcbp_checker.sv
// Port-level checker for the Huffman code bit packer, bound to the top level.
// Depends on hcbp_pkg and huffman_code_bit_packer_unit_macros.svh.
`default_nettype none

`include "huffman_code_bit_packer_unit_macros.svh"

module hcbp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic [1:0]                    op,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
    input wire logic                          last
);
    import hcbp_pkg::*;

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    // encode and flush words leave the block stalled after acceptance
    `HCBP_ASSERT_NEXT(a_busy_after_code, in_acc && (op == OP_ENCODE || op == OP_FLUSH), in_stall)
    // a load completes in its own cycle
    `HCBP_ASSERT_NEXT(a_load_single, in_acc && op == OP_LOAD, !in_stall)
    // a non-final byte is always followed at once by its partner
    `HCBP_ASSERT_NEXT(a_pair_follows, out_valid && !out_stall && !last, out_valid && last)
    `HCBP_ASSERT_HOLD(a_out_held, out_valid && out_stall, out_byte)

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
);

`default_nettype wire
